// File: src/cpwm_pkg.sv
// Package for the center-aligned complementary PWM block.
// Holds the mode and register-index codes, beat payload structs and reset constants.
package cpwm_pkg;

  localparam int unsigned DUTY_W   = 17;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DEAD_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DUTY_W-1:0]   DUTY_ONE     = 17'h1_0000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  typedef enum logic [1:0] {
    MODE_HIGH = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_OFF  = 2'd2
  } out_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_DEAD   = 2'd1,
    CFG_PERIOD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty_q16;
    logic                main_enable;
    logic                comp_enable;
    logic                brake_request;
    logic [PERIOD_W-1:0] period_request;
  } tick_beat_t;

  typedef struct packed {
    logic main_out;
    logic comp_out;
    logic at_top;
    logic at_bottom;
  } result_beat_t;

  // settings handed from the register file to the core
  typedef struct packed {
    logic [1:0]          mode_sel;
    logic [DEAD_W-1:0]   dead_count;
    logic                period_load;
    logic [PERIOD_W-1:0] period_value;
  } cfg_t;

endpackage

// File: src/cpwm_if.sv
// Valid/ready channel carrying one payload beat.
// Payload type is a parameter; used with the structs of cpwm_pkg.
interface cpwm_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/cpwm_cfg.sv
// Configuration registers: mode and dead time; period writes are passed through to the core.
// Depends on cpwm_pkg; a period write loads the core's active period unless the core steps.
module cpwm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpwm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpwm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output cpwm_pkg::cfg_t                 cfg_o
);

  logic [1:0]                        mode_q;
  logic [cpwm_pkg::DEAD_W-1:0]       dead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cpwm_pkg::MODE_HIGH;
      dead_q <= '0;
    end else if (cfg_we_i) begin
      case (cpwm_pkg::cfg_idx_e'(cfg_idx_i))
        cpwm_pkg::CFG_MODE: mode_q <= cfg_wdata_i[1:0];
        cpwm_pkg::CFG_DEAD: dead_q <= cfg_wdata_i[cpwm_pkg::DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.mode_sel     = mode_q;
    cfg_o.dead_count   = dead_q;
    cfg_o.period_load  = cfg_we_i && (cpwm_pkg::cfg_idx_e'(cfg_idx_i) == cpwm_pkg::CFG_PERIOD);
    cfg_o.period_value = cfg_wdata_i[cpwm_pkg::PERIOD_W-1:0];
  end

endmodule

// File: src/cpwm_core.sv
// Up-down counter, valley loads, output levels, brake and dead-time logic.
// Depends on cpwm_pkg; state changes only on a step strobe, or on a period write without one.
module cpwm_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cpwm_pkg::cfg_t         cfg_i,
  input  logic                   step_i,
  input  cpwm_pkg::tick_beat_t   beat_i,
  output cpwm_pkg::result_beat_t result_o
);

  localparam int unsigned CW = (COUNT_WIDTH > cpwm_pkg::DUTY_W) ? COUNT_WIDTH
                                                                : cpwm_pkg::DUTY_W;
  localparam int unsigned PW = (COUNT_WIDTH > cpwm_pkg::PERIOD_W) ? COUNT_WIDTH
                                                                  : cpwm_pkg::PERIOD_W;
  localparam int unsigned PROD_W = 2 * cpwm_pkg::DUTY_W;

  logic [COUNT_WIDTH-1:0]         count_q, count_d;
  logic [COUNT_WIDTH-1:0]         prev_count_q;
  logic                           down_q, down_d;
  logic [cpwm_pkg::DUTY_W-1:0]    cmp_q, cmp_d;
  logic [cpwm_pkg::PERIOD_W-1:0]  period_q, period_d;
  logic                           men_q, men_d;
  logic                           cen_q, cen_d;
  logic                           brake_q, brake_d;
  logic                           pmain_q, pmain_d;
  logic                           pcomp_q, pcomp_d;
  logic [cpwm_pkg::DEAD_W-1:0]    dead_q, dead_d;

  logic                           eval;
  logic                           valley;
  logic [cpwm_pkg::DUTY_W-1:0]    duty_sat;
  logic [PROD_W-1:0]              prod;
  logic                           lt;
  logic                           m, c;
  logic [cpwm_pkg::DEAD_W-1:0]    dead_ld;

  always_comb begin
    eval   = (count_q != prev_count_q);
    valley = eval && (prev_count_q > count_q) && (count_q == '0);

    duty_sat = (beat_i.duty_q16 > cpwm_pkg::DUTY_ONE) ? cpwm_pkg::DUTY_ONE
                                                       : beat_i.duty_q16;
    prod = PROD_W'(duty_sat) * PROD_W'({1'b0, period_q} + 17'd1);

    cmp_d    = valley ? prod[cpwm_pkg::DUTY_W+15:16] : cmp_q;
    men_d    = valley ? beat_i.main_enable : men_q;
    cen_d    = valley ? beat_i.comp_enable : cen_q;
    period_d = valley ? beat_i.period_request : period_q;
    brake_d  = eval ? ((brake_q && !valley) || beat_i.brake_request) : brake_q;

    lt = CW'(count_q) < CW'(cmp_d);
    case (cpwm_pkg::out_mode_e'(cfg_i.mode_sel))
      cpwm_pkg::MODE_HIGH: m = lt;
      cpwm_pkg::MODE_LOW:  m = !lt;
      default:             m = 1'b0;
    endcase
    c = !m;

    // falling edge on either output restarts the dead time
    dead_ld = ((pmain_q && !m) || (pcomp_q && !c)) ? cfg_i.dead_count : dead_q;
    if (brake_d) begin
      m = 1'b0;
      c = 1'b0;
    end
    if (dead_ld != '0) begin
      dead_d = dead_ld - 1'b1;
      m = 1'b0;
      c = 1'b0;
    end else begin
      dead_d = dead_ld;
    end
    if (!men_d) m = 1'b0;
    if (!cen_d) c = 1'b0;

    if (!eval) begin
      dead_d = dead_q;
      m = pmain_q;
      c = pcomp_q;
    end
    pmain_d = m;
    pcomp_d = c;

    // counter advance against the period now in force
    if (!down_q) begin
      count_d = count_q + 1'b1;
      down_d  = PW'(count_d) >= PW'(period_d);
    end else begin
      count_d = (count_q != '0) ? count_q - 1'b1 : count_q;
      down_d  = (count_d != '0);
    end

    result_o.main_out  = pmain_d;
    result_o.comp_out  = pcomp_d;
    result_o.at_top    = PW'(count_d) == PW'(period_d);
    result_o.at_bottom = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      prev_count_q <= '0;
      down_q       <= 1'b0;
      cmp_q        <= '0;
      period_q     <= cpwm_pkg::PERIOD_RESET;
      men_q        <= 1'b0;
      cen_q        <= 1'b0;
      brake_q      <= 1'b0;
      pmain_q      <= 1'b0;
      pcomp_q      <= 1'b0;
      dead_q       <= '0;
    end else if (step_i) begin
      count_q  <= count_d;
      down_q   <= down_d;
      period_q <= period_d;
      if (eval) begin
        prev_count_q <= count_q;
        cmp_q        <= cmp_d;
        men_q        <= men_d;
        cen_q        <= cen_d;
        brake_q      <= brake_d;
        pmain_q      <= pmain_d;
        pcomp_q      <= pcomp_d;
        dead_q       <= dead_d;
      end
    end else if (cfg_i.period_load) begin
      period_q <= cfg_i.period_value;
    end
  end

endmodule

// File: src/complementary_pwm_deadtime.sv
// Center-aligned complementary PWM with dead time: top level.
// Depends on cpwm_pkg, cpwm_if, cpwm_cfg and cpwm_core.
//
// Usage: every beat on tick_i is one timer tick and carries the duty (Q16),
// the two channel enables, a brake request and the period for the next cycle.
// Every tick gives exactly one beat on result_o with the main and
// complementary levels and the top and bottom flags of the advanced count.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle;
// a period write loads the active period at once unless the core steps in that cycle.
// A beat taken on tick_i goes into the input register; its result is then
// registered in the result register and offered on result_o. Throughput
// is one tick per cycle while result_o is ready; the counter and output
// update are one pass of logic between the input register and the result
// register, with a 17x17 multiply for the compare value at the valley.
// Reset clears the counter, latches and both beat valid flags and sets the
// period to 1000. When the receiver stalls, the result register holds and
// the input register fills; tick_i.ready drops only when both are full.
module complementary_pwm_deadtime #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpwm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpwm_pkg::CFG_W-1:0]     cfg_wdata_i,
  cpwm_if.sink                           tick_i,
  cpwm_if.source                         result_o
);

  cpwm_pkg::cfg_t         cfg;
  cpwm_pkg::tick_beat_t   in_beat_q;
  cpwm_pkg::result_beat_t out_beat_q;
  cpwm_pkg::result_beat_t core_result;
  logic                   in_valid_q, in_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic                   step;
  logic                   in_take;

  always_comb begin
    step         = in_valid_q && (!out_valid_q || result_o.ready);
    tick_i.ready = !in_valid_q || step;
    in_take      = tick_i.valid && tick_i.ready;
    in_valid_d   = in_take || (in_valid_q && !step);
    out_valid_d  = step || (out_valid_q && !result_o.ready);
    result_o.valid = out_valid_q;
    result_o.data  = out_beat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_beat_q <= tick_i.data;
    if (step) out_beat_q <= core_result;
  end

  cpwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cpwm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .beat_i   (in_beat_q),
    .result_o (core_result)
  );

endmodule

// File: bench/tb_complementary_pwm_deadtime.sv
// Self-checking bench for complementary_pwm_deadtime: ticks go in on tick_i, levels come back
// on result_o and are compared with a cycle-true prediction of counter, compare and dead time.
// Depends on cpwm_pkg, cpwm_if and the RTL under src.
module tb_complementary_pwm_deadtime;

  localparam logic [1:0] MODE_SPARE     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         NUM_PHASES     = 6;

  typedef struct {
    cpwm_pkg::tick_beat_t beat;
    bit                   keep;
  } pending_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [cpwm_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [cpwm_pkg::CFG_W-1:0]     cfg_wdata_i;

  cpwm_if #(.payload_t(cpwm_pkg::tick_beat_t))   tick_if ();
  cpwm_if #(.payload_t(cpwm_pkg::result_beat_t)) result_if ();

  complementary_pwm_deadtime DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (tick_if),
    .result_o    (result_if)
  );

  // register copies
  cpwm_pkg::out_mode_e           mode_r;
  logic [cpwm_pkg::DEAD_W-1:0]   dead_r;
  // counter and output state
  logic [15:0]                   cnt;
  logic [15:0]                   prev_cnt;
  logic                          going_down;
  logic [cpwm_pkg::DUTY_W-1:0]   cmp_val;
  logic [cpwm_pkg::PERIOD_W-1:0] top;
  logic                          main_en;
  logic                          comp_en;
  logic                          brake_on;
  logic                          last_main;
  logic                          last_comp;
  logic [cpwm_pkg::DEAD_W-1:0]   dead_left;

  pending_t               tick_q[$];
  cpwm_pkg::result_beat_t levels_q[$];

  int unsigned gap_left;
  int unsigned stall_left;
  bit          steady;
  int          mismatches;
  int          results_seen;
  int          quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic bit valley_next();
    return cnt == '0 && prev_cnt != '0;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    mismatches++;
    $display("[%0t] result %0d %s: got %b, expected %b", $time, results_seen, what, got, want);
  endtask

  // one timer tick: evaluate outputs when the count moved, then advance the counter
  task automatic step_pwm(input cpwm_pkg::tick_beat_t t);
    cpwm_pkg::result_beat_t      r;
    logic [cpwm_pkg::DUTY_W-1:0] duty;
    logic [33:0]                 prod;
    logic                        m;
    logic                        c;
    if (cnt != prev_cnt) begin
      if (prev_cnt > cnt && cnt == '0) begin
        duty     = (t.duty_q16 > cpwm_pkg::DUTY_ONE) ? cpwm_pkg::DUTY_ONE : t.duty_q16;
        prod     = 34'(duty) * (34'(top) + 34'd1);
        cmp_val  = prod[32:16];
        main_en  = t.main_enable;
        comp_en  = t.comp_enable;
        brake_on = 1'b0;
        top      = t.period_request;
      end
      if (t.brake_request) brake_on = 1'b1;
      case (mode_r)
        cpwm_pkg::MODE_HIGH: m = 17'(cnt) < cmp_val;
        cpwm_pkg::MODE_LOW:  m = !(17'(cnt) < cmp_val);
        default:             m = 1'b0;
      endcase
      c = !m;
      if ((last_main && !m) || (last_comp && !c)) dead_left = dead_r;
      if (brake_on) begin
        m = 1'b0;
        c = 1'b0;
      end
      if (dead_left != '0) begin
        dead_left--;
        m = 1'b0;
        c = 1'b0;
      end
      if (!main_en) m = 1'b0;
      if (!comp_en) c = 1'b0;
      prev_cnt  = cnt;
      last_main = m;
      last_comp = c;
    end
    if (!going_down) begin
      cnt = cnt + 16'd1;
      if (cnt >= top) going_down = 1'b1;
    end else begin
      if (cnt != '0) cnt--;
      if (cnt == '0) going_down = 1'b0;
    end
    r.main_out  = last_main;
    r.comp_out  = last_comp;
    r.at_top    = cnt == top;
    r.at_bottom = cnt == '0;
    levels_q.push_back(r);
  endtask

  task automatic write_reg(input cpwm_pkg::cfg_idx_e idx, input logic [cpwm_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cpwm_pkg::CFG_MODE:   mode_r = cpwm_pkg::out_mode_e'(val[1:0]);
      cpwm_pkg::CFG_DEAD:   dead_r = val;
      cpwm_pkg::CFG_PERIOD: top = val;
      default: ;
    endcase
  endtask

  task automatic push_ticks(input int n, input logic [cpwm_pkg::DUTY_W-1:0] duty,
                            input bit men, input bit cen, input bit brk,
                            input logic [cpwm_pkg::PERIOD_W-1:0] per, input bit keep);
    pending_t p;
    p.beat.duty_q16       = duty;
    p.beat.main_enable    = men;
    p.beat.comp_enable    = cen;
    p.beat.brake_request  = brk;
    p.beat.period_request = per;
    p.keep                = keep;
    repeat (n) tick_q.push_back(p);
  endtask

  task automatic push_random_tick();
    pending_t    p;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40)      p.beat.duty_q16 = 17'($urandom_range(65536));
    else if (r < 65) p.beat.duty_q16 = 17'($urandom_range(131071));
    else if (r < 80) p.beat.duty_q16 = cpwm_pkg::DUTY_ONE;
    else if (r < 90) p.beat.duty_q16 = '0;
    else             p.beat.duty_q16 = 17'($urandom_range(65536, 60000));
    p.beat.main_enable   = $urandom_range(9) != 0;
    p.beat.comp_enable   = $urandom_range(9) != 0;
    p.beat.brake_request = $urandom_range(19) == 0;
    if ($urandom_range(99) < 70) p.beat.period_request = 16'($urandom_range(24));
    else                         p.beat.period_request = 16'($urandom_range(65535));
    p.keep = 1'b0;
    tick_q.push_back(p);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || tick_if.valid || levels_q.size() != 0);
  endtask

  // tick driver; a wide period that would land on a valley is folded down unless pinned
  always @(posedge clk_i or negedge rst_ni) begin : drive_ticks
    pending_t nxt;
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
      tick_if.data  <= '0;
      gap_left      <= 0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        step_pwm(tick_if.data);
        if ($urandom_range(63) == 0) steady <= !steady;
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          tick_if.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          nxt = tick_q.pop_front();
          if (!nxt.keep && valley_next() && nxt.beat.period_request > 40)
            nxt.beat.period_request = 16'(nxt.beat.period_request[4:0]);
          tick_if.data  <= nxt.beat;
          tick_if.valid <= 1'b1;
          gap_left      <= pick_idle();
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    cpwm_pkg::result_beat_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        if (levels_q.size() == 0) begin
          report_mismatch("beat with nothing pending", 1'b1, 1'b0);
        end else begin
          want = levels_q.pop_front();
          if (result_if.data.main_out !== want.main_out)
            report_mismatch("main_out", result_if.data.main_out, want.main_out);
          if (result_if.data.comp_out !== want.comp_out)
            report_mismatch("comp_out", result_if.data.comp_out, want.comp_out);
          if (result_if.data.at_top !== want.at_top)
            report_mismatch("at_top", result_if.data.at_top, want.at_top);
          if (result_if.data.at_bottom !== want.at_bottom)
            report_mismatch("at_bottom", result_if.data.at_bottom, want.at_bottom);
        end
      end
      if (stall_left != 0) begin
        stall_left      <= stall_left - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        stall_left      <= pick_idle();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_if.valid && tick_if.ready) || (result_if.valid && result_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [1:0]  phase_mode [NUM_PHASES];
    int unsigned phase_dead [NUM_PHASES];
    int          phase_len  [NUM_PHASES];
    phase_mode = '{cpwm_pkg::MODE_HIGH, cpwm_pkg::MODE_LOW, cpwm_pkg::MODE_OFF, MODE_SPARE,
                   cpwm_pkg::MODE_HIGH, cpwm_pkg::MODE_LOW};
    phase_dead = '{0, 4, 8, 3, 12, 0};
    phase_len  = '{280, 280, 160, 120, 280, 70};

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = cpwm_pkg::CFG_MODE;
    cfg_wdata_i     = '0;
    tick_if.valid   = 1'b0;
    tick_if.data    = '0;
    result_if.ready = 1'b0;
    steady          = 1'b0;
    mismatches      = 0;
    results_seen    = 0;
    quiet_cycles    = 0;
    mode_r          = cpwm_pkg::MODE_HIGH;
    dead_r          = '0;
    cnt             = '0;
    prev_cnt        = '0;
    going_down      = 1'b0;
    cmp_val         = '0;
    top             = cpwm_pkg::PERIOD_RESET;
    main_en         = 1'b0;
    comp_en         = 1'b0;
    brake_on        = 1'b0;
    last_main       = 1'b0;
    last_comp       = 1'b0;
    dead_left       = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // period zero: a valley every second tick, so each pair of ticks hits one valley
    write_reg(cpwm_pkg::CFG_MODE, 16'(cpwm_pkg::MODE_HIGH));
    write_reg(cpwm_pkg::CFG_DEAD, '0);
    write_reg(cpwm_pkg::CFG_PERIOD, '0);
    push_ticks(1, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0);        // count unchanged, no evaluation
    push_ticks(2, cpwm_pkg::DUTY_ONE, 1'b1, 1'b1, 1'b0, '0, 1'b0);
    push_ticks(2, 17'h1FFFF, 1'b1, 1'b1, 1'b0, '0, 1'b0);  // saturates to full scale
    push_ticks(2, '0, 1'b1, 1'b1, 1'b0, '0, 1'b0);
    push_ticks(2, 17'h0FFFF, 1'b1, 1'b0, 1'b1, '0, 1'b0);  // brake
    wait_drained();
    write_reg(cpwm_pkg::CFG_MODE, 16'(cpwm_pkg::MODE_LOW));
    write_reg(cpwm_pkg::CFG_DEAD, 16'd1);
    push_ticks(2, cpwm_pkg::DUTY_ONE, 1'b1, 1'b1, 1'b0, '0, 1'b0);
    push_ticks(2, '0, 1'b0, 1'b1, 1'b0, '0, 1'b0);
    push_ticks(2, cpwm_pkg::DUTY_ONE, 1'b1, 1'b1, 1'b0, '0, 1'b0);
    wait_drained();
    write_reg(cpwm_pkg::CFG_MODE, 16'(cpwm_pkg::MODE_OFF));
    push_ticks(2, cpwm_pkg::DUTY_ONE, 1'b1, 1'b1, 1'b0, '0, 1'b0);
    wait_drained();
    write_reg(cpwm_pkg::CFG_MODE, 16'(MODE_SPARE));
    push_ticks(2, cpwm_pkg::DUTY_ONE, 1'b1, 1'b1, 1'b0, '0, 1'b0);
    wait_drained();

    // widest period from a request, then cut short by a register write on the way up
    write_reg(cpwm_pkg::CFG_MODE, 16'(cpwm_pkg::MODE_HIGH));
    write_reg(cpwm_pkg::CFG_DEAD, '0);
    push_ticks(2, 17'h08000, 1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b1);
    push_ticks(3, 17'h08000, 1'b1, 1'b1, 1'b0, 16'd3, 1'b0);
    wait_drained();
    write_reg(cpwm_pkg::CFG_PERIOD, 16'd2);
    while (!(going_down && cnt != '0)) begin
      push_ticks(1, 17'h08000, 1'b1, 1'b1, 1'b0, 16'd3, 1'b0);
      wait_drained();
    end
    // full-scale period at the valley: compare reaches 65536
    write_reg(cpwm_pkg::CFG_PERIOD, 16'hFFFF);
    push_ticks(8, cpwm_pkg::DUTY_ONE, 1'b1, 1'b1, 1'b0, 16'd5, 1'b0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(cpwm_pkg::CFG_MODE, 16'(phase_mode[p]));
      if (p == NUM_PHASES - 1) write_reg(cpwm_pkg::CFG_DEAD, 16'hFFFF);
      else write_reg(cpwm_pkg::CFG_DEAD, 16'($urandom_range(phase_dead[p])));
      write_reg(cpwm_pkg::CFG_PERIOD, 16'($urandom_range(30)));
      repeat (phase_len[p]) push_random_tick();
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/cpwm_pkg.sv
src/cpwm_if.sv
src/cpwm_cfg.sv
src/cpwm_core.sv
src/complementary_pwm_deadtime.sv
bench/tb_complementary_pwm_deadtime.sv
